// ===== design/bba_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// bba_pkg
// Shared types and result codes of the buddy block allocator.
// ----------------------------------------------------------------------------
package bba_pkg;

  typedef logic [1:0] status_t;

  localparam status_t STATUS_DONE     = 2'd0;
  localparam status_t STATUS_NO_SPACE = 2'd1;
  localparam status_t STATUS_BAD_ADDR = 2'd2;

  // Width of the fixed request and size fields of one item.
  localparam int unsigned REQ_W = 17;
  localparam int unsigned ADDR_W = 48;
  // Width of a shift amount (block size exponent).
  localparam int unsigned SH_W = 5;

endpackage
`default_nettype wire

// ===== design/buddy_block_allocator.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// buddy_block_allocator
// Buddy allocator over a power-of-two heap with one mark bit per tree node.
// ----------------------------------------------------------------------------
// After reset the block sweeps all 2*HEAP_BYTES/BLOCK_BYTES-1 nodes (2047 at
// the defaults) of the node mark memory clear, one node a cycle, holding
// in_stall high; cfg writes are taken throughout. One item is worked at a
// time on a simple dual-port mark memory with registered read. An allocate
// passes the setup state ST_START, then ST_RD_N, ST_RD_L, ST_RD_R and ST_EVAL
// for each inner tree node visited on the depth-first search, ST_RD_N and
// ST_LEAF on each node of the requested size, ST_BACK per backtrack step and
// ST_UP per level on the marking climb, so its cost follows the search length
// and grows with fragmentation. A release passes ST_START, then ST_FR_RD,
// ST_FR_SIB and ST_FR_CHK per level climbed and ST_FR_RD and ST_FR_SIB at the
// root. The result then waits in ST_DONE until the output register is free.
// The next item is accepted while a result still waits in the output register.
// ----------------------------------------------------------------------------
module buddy_block_allocator #(
  parameter int unsigned HEAP_BYTES  = 65536,
  parameter int unsigned BLOCK_BYTES = 64
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  // configuration: heap_base
  input  wire logic                        cfg_valid,
  output logic                             cfg_ready,
  input  wire logic [bba_pkg::ADDR_W-1:0]  cfg_data,
  // input items
  input  wire logic                        in_valid,
  output logic                             in_stall,
  input  wire logic                        in_mode,
  input  wire logic [bba_pkg::REQ_W-1:0]   in_request_bytes,
  input  wire logic [bba_pkg::ADDR_W-1:0]  in_release_address,
  // result items
  output logic                             out_valid,
  input  wire logic                        out_stall,
  output bba_pkg::status_t                 out_status,
  output logic      [bba_pkg::ADDR_W-1:0]  out_block_address,
  output logic      [bba_pkg::REQ_W-1:0]   out_granted_bytes,
  output logic      [bba_pkg::REQ_W-1:0]   out_free_bytes
);

  import bba_pkg::*;

  localparam int unsigned LOG_HEAP   = $clog2(HEAP_BYTES);
  localparam int unsigned LOG_BLK    = $clog2(BLOCK_BYTES);
  localparam int unsigned LL         = LOG_HEAP - LOG_BLK;
  localparam int unsigned LEAF_COUNT = 1 << LL;
  localparam int unsigned NODE_COUNT = 2 * LEAF_COUNT - 1;
  localparam int unsigned NODE_W     = LL + 1;
  localparam int unsigned D_W        = $clog2(LL + 2);
  localparam int unsigned FREE_W     = LOG_HEAP + 1;

  localparam logic [3:0] ST_IDLE   = 4'd0;
  localparam logic [3:0] ST_CLR    = 4'd1;
  localparam logic [3:0] ST_START  = 4'd2;
  localparam logic [3:0] ST_RD_N   = 4'd3;
  localparam logic [3:0] ST_RD_L   = 4'd4;
  localparam logic [3:0] ST_RD_R   = 4'd5;
  localparam logic [3:0] ST_EVAL   = 4'd6;
  localparam logic [3:0] ST_LEAF   = 4'd7;
  localparam logic [3:0] ST_BACK   = 4'd8;
  localparam logic [3:0] ST_UP     = 4'd9;
  localparam logic [3:0] ST_FR_RD  = 4'd10;
  localparam logic [3:0] ST_FR_SIB = 4'd11;
  localparam logic [3:0] ST_FR_CHK = 4'd12;
  localparam logic [3:0] ST_DONE   = 4'd13;

  // sequencer and item state
  logic [3:0]        state_r, state_nxt;
  logic [NODE_W-1:0] idx_r, idx_nxt;
  logic [D_W-1:0]    dep_r, dep_nxt;
  logic [D_W-1:0]    lvl_r, lvl_nxt;
  logic [SH_W-1:0]   ls_r, ls_nxt;
  logic [FREE_W-1:0] size_r, size_nxt;
  logic [FREE_W-1:0] free_r, free_nxt;
  logic              cred_r, cred_nxt;
  logic              mn_r, mn_nxt;
  logic              ml_r, ml_nxt;
  logic [ADDR_W-1:0] base_r, base_nxt;

  // captured item
  logic              mode_r;
  logic [REQ_W-1:0]  req_r;
  logic [ADDR_W-1:0] rel_addr_r;

  // result under construction and output register
  status_t           res_status_r, res_status_nxt;
  logic [ADDR_W-1:0] res_addr_r, res_addr_nxt;
  logic [FREE_W-1:0] res_gr_r, res_gr_nxt;
  logic              out_valid_r, out_valid_nxt;
  status_t           out_status_r;
  logic [ADDR_W-1:0] out_addr_r;
  logic [REQ_W-1:0]  out_gr_r;
  logic [REQ_W-1:0]  out_free_r;
  logic              out_load;

  // mark memory port
  logic              ram_we;
  logic [NODE_W-1:0] ram_waddr;
  logic              ram_wdata;
  logic [NODE_W-1:0] ram_raddr;
  logic              ram_rdata;

  logic              in_acc;

  // request rounding and release address checks
  logic [REQ_W-1:0]  req_m1;
  logic [SH_W-1:0]   clog_req;
  logic [SH_W-1:0]   ls_req;
  logic              too_big;
  logic [ADDR_W-1:0] rel_off;
  logic              rel_bad;

  // node arithmetic
  logic [NODE_W-1:0] parent_idx;
  logic [NODE_W-1:0] sib_idx;
  logic [NODE_W-1:0] lchild_idx;
  logic [NODE_W-1:0] rchild_idx;
  logic [NODE_W-1:0] first_idx;
  logic [ADDR_W-1:0] grant_off;

  bba_ram #(
    .WIDTH (1),
    .DEPTH (NODE_COUNT)
  ) u_marks (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign cfg_ready = 1'b1;
  assign in_stall  = (state_r != ST_IDLE);
  assign in_acc    = in_valid && !in_stall;
  assign out_load  = (state_r == ST_DONE) && (!out_valid_r || !out_stall);

  // Round the request up to a power of two, at least one leaf block.
  always_comb begin
    req_m1   = req_r - REQ_W'(1);
    clog_req = '0;
    if (req_r > REQ_W'(1)) begin
      for (int i = 0; i < REQ_W; i++) begin
        if (req_m1[i]) begin
          clog_req = SH_W'(i + 1);
        end
      end
    end
    ls_req  = (clog_req < SH_W'(LOG_BLK)) ? SH_W'(LOG_BLK) : clog_req;
    too_big = (ls_req > SH_W'(LOG_HEAP));
  end

  assign rel_off = rel_addr_r - base_r;
  assign rel_bad = (rel_addr_r < base_r) || (rel_off >= ADDR_W'(HEAP_BYTES)) ||
                   (rel_off[LOG_BLK-1:0] != '0);

  assign parent_idx = (idx_r - NODE_W'(1)) >> 1;
  assign sib_idx    = idx_r[0] ? (idx_r + NODE_W'(1)) : (idx_r - NODE_W'(1));
  assign lchild_idx = NODE_W'({idx_r, 1'b0} + (NODE_W+1)'(1));
  assign rchild_idx = NODE_W'({idx_r, 1'b0} + (NODE_W+1)'(2));
  assign first_idx  = (NODE_W'(1) << dep_r) - NODE_W'(1);
  assign grant_off  = ADDR_W'(idx_r - first_idx) << ls_r;

  always_comb begin
    state_nxt      = state_r;
    idx_nxt        = idx_r;
    dep_nxt        = dep_r;
    lvl_nxt        = lvl_r;
    ls_nxt         = ls_r;
    size_nxt       = size_r;
    free_nxt       = free_r;
    cred_nxt       = cred_r;
    mn_nxt         = mn_r;
    ml_nxt         = ml_r;
    base_nxt       = base_r;
    res_status_nxt = res_status_r;
    res_addr_nxt   = res_addr_r;
    res_gr_nxt     = res_gr_r;
    out_valid_nxt  = out_valid_r;
    ram_we         = 1'b0;
    ram_waddr      = idx_r;
    ram_wdata      = 1'b0;
    ram_raddr      = idx_r;

    if (cfg_valid) begin
      base_nxt = cfg_data;
    end
    // drop the result once taken
    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      ST_CLR: begin
        ram_we    = 1'b1;
        ram_waddr = idx_r;
        ram_wdata = 1'b0;
        idx_nxt   = idx_r + NODE_W'(1);
        if (idx_r == NODE_W'(NODE_COUNT - 1)) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_acc) begin
          state_nxt = ST_START;
        end
      end
      ST_START: begin
        res_status_nxt = STATUS_DONE;
        res_addr_nxt   = '0;
        res_gr_nxt     = '0;
        if (!mode_r) begin
          if (too_big) begin
            res_status_nxt = STATUS_NO_SPACE;
            state_nxt      = ST_DONE;
          end else begin
            ls_nxt    = ls_req;
            lvl_nxt   = D_W'(SH_W'(LOG_HEAP) - ls_req);
            size_nxt  = FREE_W'(1) << ls_req;
            idx_nxt   = '0;
            dep_nxt   = '0;
            state_nxt = ST_RD_N;
          end
        end else begin
          if (rel_bad) begin
            res_status_nxt = STATUS_BAD_ADDR;
            state_nxt      = ST_DONE;
          end else begin
            idx_nxt   = NODE_W'(rel_off >> LOG_BLK) + NODE_W'(LEAF_COUNT - 1);
            size_nxt  = FREE_W'(BLOCK_BYTES);
            cred_nxt  = 1'b0;
            state_nxt = ST_FR_RD;
          end
        end
      end
      ST_RD_N: begin
        ram_raddr = idx_r;
        state_nxt = (dep_r == lvl_r) ? ST_LEAF : ST_RD_L;
      end
      ST_RD_L: begin
        ram_raddr = lchild_idx;
        mn_nxt    = ram_rdata;
        state_nxt = ST_RD_R;
      end
      ST_RD_R: begin
        ram_raddr = rchild_idx;
        ml_nxt    = ram_rdata;
        state_nxt = ST_EVAL;
      end
      ST_EVAL: begin
        // a fully taken node has its mark set and both children clear
        if (mn_r && !ml_r && !ram_rdata) begin
          state_nxt = ST_BACK;
        end else begin
          idx_nxt   = lchild_idx;
          dep_nxt   = dep_r + D_W'(1);
          state_nxt = ST_RD_N;
        end
      end
      ST_LEAF: begin
        if (ram_rdata) begin
          state_nxt = ST_BACK;
        end else begin
          res_addr_nxt = base_r + grant_off;
          state_nxt    = ST_UP;
        end
      end
      ST_BACK: begin
        priority if (idx_r == '0) begin
          res_status_nxt = STATUS_NO_SPACE;
          res_addr_nxt   = '0;
          state_nxt      = ST_DONE;
        end else if (idx_r[0]) begin
          // left child failed: try its buddy
          idx_nxt   = idx_r + NODE_W'(1);
          state_nxt = ST_RD_N;
        end else begin
          // right child failed: the parent fails too
          idx_nxt = parent_idx;
          dep_nxt = dep_r - D_W'(1);
        end
      end
      ST_UP: begin
        ram_we    = 1'b1;
        ram_waddr = idx_r;
        ram_wdata = 1'b1;
        if (idx_r == '0) begin
          free_nxt   = free_r - size_r;
          res_gr_nxt = size_r;
          state_nxt  = ST_DONE;
        end else begin
          idx_nxt = parent_idx;
        end
      end
      ST_FR_RD: begin
        ram_raddr = idx_r;
        state_nxt = ST_FR_SIB;
      end
      ST_FR_SIB: begin
        if (ram_rdata && !cred_r) begin
          free_nxt   = free_r + size_r;
          res_gr_nxt = size_r;
          cred_nxt   = 1'b1;
        end
        ram_we    = 1'b1;
        ram_waddr = idx_r;
        ram_wdata = 1'b0;
        ram_raddr = sib_idx;
        state_nxt = (idx_r == '0) ? ST_DONE : ST_FR_CHK;
      end
      ST_FR_CHK: begin
        if (ram_rdata) begin
          state_nxt = ST_DONE;
        end else begin
          idx_nxt   = parent_idx;
          size_nxt  = size_r << 1;
          state_nxt = ST_FR_RD;
        end
      end
      ST_DONE: begin
        if (out_load) begin
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLR;
      idx_r       <= '0;
      free_r      <= FREE_W'(HEAP_BYTES);
      base_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      idx_r       <= idx_nxt;
      free_r      <= free_nxt;
      base_r      <= base_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload and working registers, no reset needed
  always_ff @(posedge clk) begin
    dep_r        <= dep_nxt;
    lvl_r        <= lvl_nxt;
    ls_r         <= ls_nxt;
    size_r       <= size_nxt;
    cred_r       <= cred_nxt;
    mn_r         <= mn_nxt;
    ml_r         <= ml_nxt;
    res_status_r <= res_status_nxt;
    res_addr_r   <= res_addr_nxt;
    res_gr_r     <= res_gr_nxt;
    if (in_acc) begin
      mode_r     <= in_mode;
      req_r      <= in_request_bytes;
      rel_addr_r <= in_release_address;
    end
    if (out_load) begin
      out_status_r <= res_status_r;
      out_addr_r   <= res_addr_r;
      out_gr_r     <= REQ_W'(res_gr_r);
      out_free_r   <= REQ_W'(free_r);
    end
  end

  assign out_valid         = out_valid_r;
  assign out_status        = out_status_r;
  assign out_block_address = out_addr_r;
  assign out_granted_bytes = out_gr_r;
  assign out_free_bytes    = out_free_r;

  // hold off the next item until this one is finished
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> in_stall)
    else $error("item accepted while block was idle but stall dropped");

  a_free_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    free_r <= FREE_W'(HEAP_BYTES))
    else $error("free count exceeds heap size");

  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_status == STATUS_DONE || out_status == STATUS_NO_SPACE ||
                   out_status == STATUS_BAD_ADDR))
    else $error("undefined status code");

  a_fail_zero_addr: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status != STATUS_DONE) |-> (out_block_address == '0 &&
                                                  out_granted_bytes == '0))
    else $error("failed item carries an address or size");

endmodule
`default_nettype wire

// ===== design/bba_ram.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// bba_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module bba_ram #(
  parameter int unsigned WIDTH = 1,
  parameter int unsigned DEPTH = 2047
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

// ===== test/tb_buddy_block_allocator.sv =====
// ----------------------------------------------------------------------------
// tb_buddy_block_allocator
// Self-checking bench: directed table then random allocate/release traffic,
// every result compared with a tree-bitmap model of the buddy allocator.
// ----------------------------------------------------------------------------
module tb_buddy_block_allocator;
  timeunit 1ns;
  timeprecision 1ps;
  import bba_pkg::*;

  localparam int unsigned HEAP  = 65536;
  localparam int unsigned BLK   = 64;
  localparam int unsigned LEAVES = HEAP / BLK;
  localparam int unsigned NODES  = 2 * LEAVES - 1;
  localparam logic MODE_ALLOC   = 1'b0;
  localparam logic MODE_RELEASE = 1'b1;
  localparam logic [47:0] TOP_ADDR = 48'hFFFF_FFFF_FFFF;

  typedef struct packed {
    status_t     status;
    logic [47:0] block_address;
    logic [16:0] granted_bytes;
    logic [16:0] free_bytes;
  } alloc_result_t;

  typedef struct {
    logic          mode;
    logic [16:0]   req;
    logic [47:0]   addr;
    logic          known;   // expected result typed in below
    alloc_result_t res;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [47:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic in_mode = 1'b0;
  logic [16:0] in_request_bytes = '0;
  logic [47:0] in_release_address = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  status_t out_status;
  logic [47:0] out_block_address;
  logic [16:0] out_granted_bytes;
  logic [16:0] out_free_bytes;

  always #1 clk = ~clk;

  buddy_block_allocator i_dut (
    .clk(clk), .rst_n(rst_n),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_stall(in_stall), .in_mode(in_mode),
    .in_request_bytes(in_request_bytes), .in_release_address(in_release_address),
    .out_valid(out_valid), .out_stall(out_stall), .out_status(out_status),
    .out_block_address(out_block_address), .out_granted_bytes(out_granted_bytes),
    .out_free_bytes(out_free_bytes)
  );

  // Shadow of the allocator: tree marks, free count and heap base.
  bit          tree_marks [NODES];
  int unsigned free_total;
  logic [47:0] base_addr;
  alloc_result_t pending_results[$];
  bit          override_valid;
  alloc_result_t override_res;

  int unsigned errors = 0;
  int unsigned items_sent = 0;
  int unsigned results_seen = 0;
  int unsigned grants = 0;
  int unsigned credits = 0;
  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;
  logic [47:0] live_blocks[$];   // addresses granted and not yet released

  function automatic bit marked(int unsigned n);
    return n < NODES && tree_marks[n];
  endfunction

  // Depth-first search for a free node `depth` levels below `n`.
  function automatic bit claim_node(int unsigned n, int unsigned depth,
                                    int unsigned offs, int unsigned span,
                                    ref int unsigned hit);
    if (depth == 0) begin
      if (marked(n)) return 1'b0;
      tree_marks[n] = 1'b1;
      hit = offs;
      return 1'b1;
    end
    if (marked(n) && !marked(2 * n + 1) && !marked(2 * n + 2)) return 1'b0;
    if (!claim_node(2 * n + 1, depth - 1, offs, span / 2, hit) &&
        !claim_node(2 * n + 2, depth - 1, offs + span / 2, span / 2, hit))
      return 1'b0;
    tree_marks[n] = 1'b1;
    return 1'b1;
  endfunction

  function automatic alloc_result_t predict_alloc(logic mode, logic [16:0] req,
                                                  logic [47:0] addr);
    alloc_result_t r;
    int unsigned size, depth, s, hit, n;
    logic [47:0] offs;
    bit done;
    r = '0;
    if (mode == MODE_ALLOC) begin
      size = 1;
      while (size < req) size <<= 1;
      if (size < BLK) size = BLK;
      if (size > HEAP) begin
        r.status = STATUS_NO_SPACE;
      end else begin
        depth = 0;
        s = size;
        hit = 0;
        while (s < HEAP) begin
          s <<= 1;
          depth++;
        end
        if (claim_node(0, depth, 0, HEAP, hit)) begin
          free_total -= size;
          r.block_address = base_addr + 48'(hit);
          r.granted_bytes = 17'(size);
        end else begin
          r.status = STATUS_NO_SPACE;
        end
      end
    end else begin
      offs = addr - base_addr;
      if (addr < base_addr || offs >= HEAP || offs % BLK != 0) begin
        r.status = STATUS_BAD_ADDR;
      end else begin
        n = int'(offs / BLK) + LEAVES - 1;
        size = BLK;
        done = 1'b0;
        forever begin
          if (marked(n) && !done) begin
            free_total += size;
            r.granted_bytes = 17'(size);
            done = 1'b1;
          end
          tree_marks[n] = 1'b0;
          if (n == 0) break;
          if (marked((n & 1) ? n + 1 : n - 1)) break;
          n = (n - 1) / 2;
          size <<= 1;
        end
      end
    end
    r.free_bytes = 17'(free_total);
    return r;
  endfunction

  // Send one item; hold it until accepted, then advance the model.
  // Valid stays high after acceptance; the block stalls until it is idle, and
  // the next call or drain() replaces or drops the item in that same step.
  task automatic send_item(logic mode, logic [16:0] req, logic [47:0] addr);
    alloc_result_t r;
    while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_mode <= mode;
    in_request_bytes <= req;
    in_release_address <= addr;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    r = predict_alloc(mode, req, addr);
    if (override_valid && r != override_res) begin
      $error("directed row: typed result %p, model %p", override_res, r);
      errors++;
    end
    pending_results.push_back(r);
    items_sent++;
    if (mode == MODE_ALLOC && r.status == STATUS_DONE) begin
      live_blocks.push_back(r.block_address);
      grants++;
    end
    if (mode == MODE_RELEASE && r.granted_bytes != 0) credits++;
  endtask

  // Receiver: random stall, compare each accepted result with the oldest one.
  always @(posedge clk) begin
    alloc_result_t exp_r;
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        results_seen++;
        if (pending_results.size() == 0) begin
          $error("unexpected result, nothing pending");
          errors++;
        end else begin
          exp_r = pending_results.pop_front();
          if (out_status !== exp_r.status) begin
            $error("status exp %0d got %0d", exp_r.status, out_status);
            errors++;
          end
          if (out_block_address !== exp_r.block_address) begin
            $error("block_address exp %h got %h", exp_r.block_address,
                   out_block_address);
            errors++;
          end
          if (out_granted_bytes !== exp_r.granted_bytes) begin
            $error("granted_bytes exp %0d got %0d", exp_r.granted_bytes,
                   out_granted_bytes);
            errors++;
          end
          if (out_free_bytes !== exp_r.free_bytes) begin
            $error("free_bytes exp %0d got %0d", exp_r.free_bytes, out_free_bytes);
            errors++;
          end
        end
      end
      out_stall <= (recv_idle_pct != 0 && $urandom_range(99) < recv_idle_pct);
    end
  end

  task automatic drain();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
  endtask

  task automatic write_base(logic [47:0] value);
    cfg_valid <= 1'b1;
    cfg_data <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    base_addr = value;
  endtask

  // Random item: mostly allocations and releases of live blocks, some noise.
  task automatic random_item();
    int unsigned pick, k;
    logic [47:0] a;
    logic [16:0] q;
    pick = $urandom_range(99);
    if (pick < 45) begin
      // small sizes dominate; a few large or oversize ones
      case ($urandom_range(9))
        0: q = 17'($urandom);
        1: q = 17'($urandom_range(65536, 16384));
        default: q = 17'($urandom_range(1024));
      endcase
      send_item(MODE_ALLOC, q, 48'($urandom));
    end else if (pick < 85 && live_blocks.size() != 0) begin
      k = $urandom_range(live_blocks.size() - 1);
      a = live_blocks[k];
      live_blocks.delete(k);
      send_item(MODE_RELEASE, 17'($urandom), a);
    end else if (pick < 93) begin
      // aligned address anywhere in the heap, possibly free or inside a block
      a = base_addr + 48'($urandom_range(LEAVES - 1) * BLK);
      send_item(MODE_RELEASE, 17'($urandom), a);
    end else begin
      a = 48'({$urandom, $urandom});
      send_item(MODE_RELEASE, 17'($urandom), a);
    end
  endtask

  stim_row_t directed[$];

  function automatic stim_row_t row(logic m, logic [16:0] q, logic [47:0] a,
                                    bit k = 0, status_t st = STATUS_DONE,
                                    logic [47:0] ba = '0, logic [16:0] gb = '0,
                                    logic [16:0] fb = '0);
    stim_row_t t;
    t.mode = m;
    t.req = q;
    t.addr = a;
    t.known = k;
    t.res = '{st, ba, gb, fb};
    return t;
  endfunction

  initial begin
    int unsigned phase;
    logic [47:0] bases[4];
    bases[0] = 48'h0;
    bases[1] = 48'h0000_1234_0000;
    bases[2] = TOP_ADDR - 48'h7FFF;   // heap wraps past the top of the space
    bases[3] = 48'hFFFF_FFFF_0000;
    ref_init();
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed table at heap_base zero, straight after reset.
    directed.push_back(row(MODE_ALLOC, 17'd0, '0, 1, STATUS_DONE, 48'd0, 17'd64, 17'd65472));
    directed.push_back(row(MODE_ALLOC, 17'd1, '0, 1, STATUS_DONE, 48'd64, 17'd64, 17'd65408));
    directed.push_back(row(MODE_ALLOC, 17'd65, '0));
    directed.push_back(row(MODE_ALLOC, 17'h1FFFF, '0, 1, STATUS_NO_SPACE, '0, '0, 17'd65280));
    directed.push_back(row(MODE_ALLOC, 17'd65537, '0, 1, STATUS_NO_SPACE, '0, '0, 17'd65280));
    directed.push_back(row(MODE_ALLOC, 17'd65536, '0, 1, STATUS_NO_SPACE, '0, '0, 17'd65280));
    directed.push_back(row(MODE_RELEASE, 17'h1FFFF, 48'd1, 1, STATUS_BAD_ADDR, '0, '0, 17'd65280));
    directed.push_back(row(MODE_RELEASE, '0, 48'd65536, 1, STATUS_BAD_ADDR, '0, '0, 17'd65280));
    directed.push_back(row(MODE_RELEASE, '0, TOP_ADDR, 1, STATUS_BAD_ADDR, '0, '0, 17'd65280));
    directed.push_back(row(MODE_RELEASE, '0, 48'd64, 1, STATUS_DONE, '0, 17'd64, 17'd65344));
    directed.push_back(row(MODE_RELEASE, '0, 48'd64));          // already free
    directed.push_back(row(MODE_RELEASE, '0, 48'd192));         // inside a block
    directed.push_back(row(MODE_RELEASE, '0, 48'd0));
    directed.push_back(row(MODE_ALLOC, 17'd65536, '0, 1, STATUS_DONE, '0, 17'd65536, '0));
    directed.push_back(row(MODE_ALLOC, 17'd0, '0, 1, STATUS_NO_SPACE, '0, '0, '0));
    directed.push_back(row(MODE_RELEASE, '0, 48'd32768));       // inside whole heap
    directed.push_back(row(MODE_ALLOC, 17'd32768, '0));
    directed.push_back(row(MODE_ALLOC, 17'd16384, '0));
    directed.push_back(row(MODE_ALLOC, 17'd16383, '0));
    directed.push_back(row(MODE_RELEASE, '0, 48'd32768));
    directed.push_back(row(MODE_RELEASE, '0, 48'd49152));
    directed.push_back(row(MODE_RELEASE, '0, 48'd0));
    foreach (directed[i]) begin
      override_valid = directed[i].known;
      override_res = directed[i].res;
      send_item(directed[i].mode, directed[i].req, directed[i].addr);
    end
    override_valid = 1'b0;
    drain();

    // Random phases: heap_base changes only while the block is idle.
    for (phase = 0; phase < 12; phase++) begin
      write_base(phase == 0 ? TOP_ADDR : bases[phase % 4]);
      send_idle_pct = (phase < 4) ? 35 : (phase < 8) ? 68 : 0;
      recv_idle_pct = (phase < 4) ? 68 : (phase < 8) ? 35 : 0;
      repeat (115) random_item();
      // release every live block so the next base starts from a clean heap
      while (live_blocks.size() != 0)
        send_item(MODE_RELEASE, '0, live_blocks.pop_front());
      drain();
    end
    recv_idle_pct = 0;
    repeat (2) @(posedge clk);

    $display("Covered %0d items: %0d grants, %0d credited releases, %0d results.",
             items_sent, grants, credits, results_seen);
    if (errors == 0 && pending_results.size() == 0)
      $display("PASSED: all results match");
    else
      $display("FAILED: results differ");
    $finish;
  end

  // Clear the model state to match reset.
  task automatic ref_init();
    foreach (tree_marks[i]) tree_marks[i] = 1'b0;
    free_total = HEAP;
    base_addr = '0;
    override_valid = 1'b0;
  endtask

  initial begin
    #200ms;
    $display("FAILED: results differ");
    $finish;
  end
endmodule
